>>> rtl/imu_rs_pkg.sv
// Shared types and constants for the IMU linear resampler.
package imu_rs_pkg;

	localparam int MAX_OUTPUTS = 20;
	localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);

	localparam logic [15:0] PERIOD_RST = 16'd5000;
	localparam logic [31:0] START_RST  = 32'd0;
	localparam logic [5:0]  JUMP_RST   = 6'd20;

	// quotient bits of one interpolation divide
	localparam logic [5:0] INTERP_DIV_STEPS = 6'd34;
	// bits of the previous time for the grid remainder
	localparam logic [5:0] GRID_DIV_STEPS   = 6'd48;

	typedef enum logic [1:0] {
		REG_PERIOD = 2'd0,
		REG_START  = 2'd1,
		REG_JUMP   = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_JMUL,
		ST_CHECK,
		ST_REM,
		ST_GRID,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV_INIT,
		ST_DIV,
		ST_SCALE,
		ST_STORE,
		ST_EMIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

endpackage

>>> rtl/imu_linear_resampler.sv
// Top level of the IMU linear resampler: sequencer, shared multiplier and divider.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | stamp_us, rate_xyz, force_xyz
//   out     | out_valid/ out_ready | grid_time_us, dtheta_abc, dvel_abc, last
//   cfg     | cfg_we               | cfg_addr, cfg_wdata
//
// A first sample is stored while the sequencer stays idle. A later one goes
// straight to FINISH when its time does not advance, else it yields up to
// MAX_OUTPUTS grid words, using the one-bit-per-cycle divider: 48 steps for the
// grid remainder, 34 per axis. Reset clears the sequencer and loads the register defaults.
// in_ready is high only while idle; a stalled output word holds the sequencer.
module imu_linear_resampler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [47:0]        stamp_us,
	input  logic signed [31:0] rate_x,
	input  logic signed [31:0] rate_y,
	input  logic signed [31:0] rate_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [47:0]        grid_time_us,
	output logic signed [47:0] dtheta_a,
	output logic signed [47:0] dtheta_b,
	output logic signed [47:0] dtheta_c,
	output logic signed [47:0] dvel_a,
	output logic signed [47:0] dvel_b,
	output logic signed [47:0] dvel_c,
	output logic               last
);

	imu_rs_pkg::state_t state_q, state_d;

	logic [15:0] per_q;
	logic [31:0] start_q;
	logic [5:0]  jl_q;

	logic                have_q;
	logic signed [48:0]  base_q;
	logic [47:0]         prev_q;
	logic signed [31:0]  pv_q [6];
	logic signed [31:0]  cur_q [6];
	logic [47:0]         stamp_q;
	logic [47:0]         rel_q;
	logic [21:0]         d_q;
	logic [47:0]         t_q;
	logic [imu_rs_pkg::CNT_W-1:0] cnt_q;
	logic [2:0]          axis_q;
	logic signed [57:0]  prod_q;
	logic signed [57:0]  acc_q;
	logic                neg_q;
	logic signed [47:0]  v_q [6];
	logic [47:0]         grid_q;
	logic                last_q;

	logic                   in_acc;
	logic                   out_acc;
	logic [15:0]            perx;
	logic signed [50:0]     raw;
	logic signed [50:0]     lim;
	logic signed [50:0]     prev51;
	logic                   jump;
	logic [48:0]            step_t;
	logic [47:0]            reln;
	logic [48:0]            base_n;
	logic [48:0]            t_first;
	logic [48:0]            t_next;
	logic [47:0]            wa;
	logic [47:0]            wb;
	logic [47:0]            dfull;
	logic signed [33:0]     mul_a;
	logic signed [23:0]     mul_b;
	logic signed [57:0]     mul_p;
	logic signed [57:0]     nsum;
	logic signed [57:0]     nn;
	logic [57:0]            den58;
	logic [57:0]            mm;
	logic [33:0]            qmag;
	logic [33:0]            qval;
	logic [47:0]            pval;
	logic                   last_n;

	imu_rs_pkg::div_ctl_t div_ctl;
	logic [23:0]          div_load_rem;
	logic [47:0]          div_load_sh;
	logic [5:0]           div_load_cnt;
	logic [23:0]          div_den;
	logic [23:0]          div_rem;
	logic [47:0]          div_sh;
	logic                 div_busy;

	assign in_ready  = state_q == imu_rs_pkg::ST_IDLE;
	assign out_valid = state_q == imu_rs_pkg::ST_EMIT;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	assign perx   = (per_q == 16'd0) ? 16'd1 : per_q;
	assign raw    = $signed({3'b000, stamp_q}) - $signed({{2{base_q[48]}}, base_q});
	assign prev51 = $signed({3'b000, prev_q});
	assign lim    = prev51 + $signed({28'd0, prod_q[22:0]});
	assign jump   = (raw < prev51) || (raw > lim);
	assign step_t = {1'b0, prev_q} + {33'd0, perx};
	assign reln   = jump ? step_t[47:0] : raw[47:0];
	assign base_n = {1'b0, stamp_q} - {1'b0, reln};
	assign dfull  = reln - prev_q;

	assign t_first = {1'b0, prev_q} - {33'd0, div_rem[15:0]} + {33'd0, perx};
	assign t_next  = {1'b0, t_q} + {33'd0, perx};
	assign wa      = rel_q - t_q;
	assign wb      = t_q - prev_q;
	assign last_n  = (t_next > {1'b0, rel_q}) ||
		(cnt_q == imu_rs_pkg::CNT_W'(imu_rs_pkg::MAX_OUTPUTS - 1));

	// rounding numerator 2*num + d, folded to a magnitude for floor division
	assign nsum  = acc_q + prod_q;
	assign nn    = $signed({nsum[56:0], 1'b0}) + $signed({36'd0, d_q});
	assign den58 = {35'd0, d_q, 1'b0};
	assign mm    = nn[57] ? (58'(-nn) + den58 - 58'd1) : 58'(nn);
	assign qmag  = div_sh[33:0];
	assign qval  = neg_q ? (34'd0 - qmag) : qmag;
	assign pval  = prod_q[47:0];

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			imu_rs_pkg::ST_JMUL: begin
				mul_a = $signed({28'd0, jl_q});
				mul_b = $signed({8'd0, perx});
			end
			imu_rs_pkg::ST_MUL_A: begin
				mul_a = 34'(pv_q[axis_q]);
				mul_b = $signed({2'b00, wa[21:0]});
			end
			imu_rs_pkg::ST_MUL_B: begin
				mul_a = 34'(cur_q[axis_q]);
				mul_b = $signed({2'b00, wb[21:0]});
			end
			imu_rs_pkg::ST_SCALE: begin
				mul_a = $signed(qval);
				mul_b = $signed({8'd0, perx});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		state_d      = state_q;
		div_ctl      = '0;
		div_load_rem = '0;
		div_load_sh  = '0;
		div_load_cnt = '0;
		div_den      = {8'd0, perx};
		unique case (state_q)
			imu_rs_pkg::ST_IDLE: begin
				if (in_acc && have_q) begin
					state_d = imu_rs_pkg::ST_JMUL;
				end
			end
			imu_rs_pkg::ST_JMUL: begin
				state_d = imu_rs_pkg::ST_CHECK;
			end
			imu_rs_pkg::ST_CHECK: begin
				if (reln > prev_q) begin
					div_ctl.load = 1'b1;
					div_load_sh  = prev_q;
					div_load_cnt = imu_rs_pkg::GRID_DIV_STEPS;
					state_d      = imu_rs_pkg::ST_REM;
				end else begin
					state_d = imu_rs_pkg::ST_FINISH;
				end
			end
			imu_rs_pkg::ST_REM: begin
				div_ctl.step = 1'b1;
				if (!div_busy) begin
					state_d = imu_rs_pkg::ST_GRID;
				end
			end
			imu_rs_pkg::ST_GRID: begin
				state_d = (t_first > {1'b0, rel_q}) ? imu_rs_pkg::ST_FINISH
					: imu_rs_pkg::ST_MUL_A;
			end
			imu_rs_pkg::ST_MUL_A: begin
				state_d = imu_rs_pkg::ST_MUL_B;
			end
			imu_rs_pkg::ST_MUL_B: begin
				state_d = imu_rs_pkg::ST_DIV_INIT;
			end
			imu_rs_pkg::ST_DIV_INIT: begin
				div_ctl.load = 1'b1;
				div_load_rem = mm[57:34];
				div_load_sh  = {mm[33:0], 14'd0};
				div_load_cnt = imu_rs_pkg::INTERP_DIV_STEPS;
				div_den      = {1'b0, d_q, 1'b0};
				state_d      = imu_rs_pkg::ST_DIV;
			end
			imu_rs_pkg::ST_DIV: begin
				div_ctl.step = 1'b1;
				div_den      = {1'b0, d_q, 1'b0};
				if (!div_busy) begin
					state_d = imu_rs_pkg::ST_SCALE;
				end
			end
			imu_rs_pkg::ST_SCALE: begin
				state_d = imu_rs_pkg::ST_STORE;
			end
			imu_rs_pkg::ST_STORE: begin
				state_d = (axis_q == 3'd5) ? imu_rs_pkg::ST_EMIT : imu_rs_pkg::ST_MUL_A;
			end
			imu_rs_pkg::ST_EMIT: begin
				if (out_acc) begin
					state_d = last_q ? imu_rs_pkg::ST_FINISH : imu_rs_pkg::ST_MUL_A;
				end
			end
			imu_rs_pkg::ST_FINISH: begin
				state_d = imu_rs_pkg::ST_IDLE;
			end
			default: begin
				state_d = imu_rs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imu_rs_pkg::ST_IDLE;
			have_q  <= 1'b0;
			per_q   <= imu_rs_pkg::PERIOD_RST;
			start_q <= imu_rs_pkg::START_RST;
			jl_q    <= imu_rs_pkg::JUMP_RST;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				have_q <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					imu_rs_pkg::REG_PERIOD: per_q   <= cfg_wdata[15:0];
					imu_rs_pkg::REG_START:  start_q <= cfg_wdata;
					imu_rs_pkg::REG_JUMP:   jl_q    <= cfg_wdata[5:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			imu_rs_pkg::ST_IDLE: begin
				if (in_acc) begin
					stamp_q  <= stamp_us;
					cur_q[0] <= rate_x;
					cur_q[1] <= rate_y;
					cur_q[2] <= rate_z;
					cur_q[3] <= force_x;
					cur_q[4] <= force_y;
					cur_q[5] <= force_z;
					if (!have_q) begin
						// first sample: set the time base and store
						base_q   <= $signed({1'b0, stamp_us} - {17'd0, start_q});
						prev_q   <= {16'd0, start_q};
						pv_q[0]  <= rate_x;
						pv_q[1]  <= rate_y;
						pv_q[2]  <= rate_z;
						pv_q[3]  <= force_x;
						pv_q[4]  <= force_y;
						pv_q[5]  <= force_z;
					end
				end
			end
			imu_rs_pkg::ST_JMUL: begin
				prod_q <= mul_p;
			end
			imu_rs_pkg::ST_CHECK: begin
				rel_q  <= reln;
				base_q <= $signed(base_n);
				d_q    <= dfull[21:0];
			end
			imu_rs_pkg::ST_GRID: begin
				t_q    <= t_first[47:0];
				cnt_q  <= '0;
				axis_q <= 3'd0;
			end
			imu_rs_pkg::ST_MUL_A: begin
				prod_q <= mul_p;
			end
			imu_rs_pkg::ST_MUL_B: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			imu_rs_pkg::ST_DIV_INIT: begin
				neg_q <= nn[57];
			end
			imu_rs_pkg::ST_SCALE: begin
				prod_q <= mul_p;
			end
			imu_rs_pkg::ST_STORE: begin
				// negate the z axes after the period product
				if (axis_q == 3'd2 || axis_q == 3'd5) begin
					v_q[axis_q] <= $signed(48'd0 - pval);
				end else begin
					v_q[axis_q] <= $signed(pval);
				end
				if (axis_q == 3'd5) begin
					grid_q <= t_q;
					last_q <= last_n;
				end else begin
					axis_q <= axis_q + 3'd1;
				end
			end
			imu_rs_pkg::ST_EMIT: begin
				if (out_acc) begin
					t_q    <= t_next[47:0];
					cnt_q  <= cnt_q + imu_rs_pkg::CNT_W'(1);
					axis_q <= 3'd0;
				end
			end
			imu_rs_pkg::ST_FINISH: begin
				prev_q <= rel_q;
				for (int i = 0; i < 6; i++) begin
					pv_q[i] <= cur_q[i];
				end
			end
			default: ;
		endcase
	end

	imu_rs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.load_rem (div_load_rem),
		.load_sh  (div_load_sh),
		.load_cnt (div_load_cnt),
		.den      (div_den),
		.rem      (div_rem),
		.sh       (div_sh),
		.busy     (div_busy)
	);

	// remap to (y, x, -z)
	assign grid_time_us = grid_q;
	assign dtheta_a     = v_q[1];
	assign dtheta_b     = v_q[0];
	assign dtheta_c     = v_q[2];
	assign dvel_a       = v_q[4];
	assign dvel_b       = v_q[3];
	assign dvel_c       = v_q[5];
	assign last         = last_q;

endmodule

>>> rtl/imu_rs_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divides.
module imu_rs_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  imu_rs_pkg::div_ctl_t ctl,
	input  logic [23:0]          load_rem,
	input  logic [47:0]          load_sh,
	input  logic [5:0]           load_cnt,
	input  logic [23:0]          den,
	output logic [23:0]          rem,
	output logic [47:0]          sh,
	output logic                 busy
);

	logic [5:0]  cnt_q;
	logic [23:0] rem_q;
	logic [47:0] sh_q;
	logic [24:0] trial;
	logic [24:0] diff;
	logic        ge;
	logic        run;

	assign run   = ctl.step && (cnt_q != 6'd0);
	assign trial = {rem_q, sh_q[47]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (ctl.load) begin
			cnt_q <= load_cnt;
		end else if (run) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= load_rem;
			sh_q  <= load_sh;
		end else if (run) begin
			// subtract when the trial remainder covers the divisor
			rem_q <= ge ? diff[23:0] : trial[23:0];
			sh_q  <= {sh_q[46:0], ge};
		end
	end

	assign rem  = rem_q;
	assign sh   = sh_q;
	assign busy = cnt_q != 6'd0;

endmodule

>>> rtl/imu_rs_chk.sv
// Port-level checker for the IMU linear resampler, bound to the top level.
module imu_rs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] grid_time_us,
	input logic        last
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while an output word waits");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(grid_time_us) && $stable(last))
		else $error("stalled output word changed");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid)
		else $error("output word follows the last one");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready)
		else $error("ready before the last output word");

	a_grid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> grid_time_us != 48'd0)
		else $error("grid time of zero emitted");

endmodule

bind imu_linear_resampler imu_rs_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.grid_time_us (grid_time_us),
	.last         (last)
);

>>> tb/sv/imu_linear_resampler_checker.sv
// Predictor and scoreboard for the IMU linear resampler: watches cfg, in and out channels.
`timescale 1ns / 1ps

module imu_linear_resampler_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [47:0]        stamp_us,
	input  logic signed [31:0] rate_x,
	input  logic signed [31:0] rate_y,
	input  logic signed [31:0] rate_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [47:0]        grid_time_us,
	input  logic signed [47:0] dtheta_a,
	input  logic signed [47:0] dtheta_b,
	input  logic signed [47:0] dtheta_c,
	input  logic signed [47:0] dvel_a,
	input  logic signed [47:0] dvel_b,
	input  logic signed [47:0] dvel_c,
	input  logic               last,
	output int                 errors,
	output int                 pending
);

	localparam longint MASK48 = 64'h0000_FFFF_FFFF_FFFF;

	typedef struct {
		logic [47:0] t;
		logic [47:0] th_a, th_b, th_c;
		logic [47:0] dv_a, dv_b, dv_c;
		logic        lst;
	} grid_word_t;

	grid_word_t grid_q[$];

	logic [15:0] period;
	logic [31:0] start_off;
	logic [5:0]  jlim;
	bit          have_prev;
	longint      base_off;
	longint      prev_t;
	longint      prev_vec[6];

	assign pending = grid_q.size();

	// round half up: floor((num/d) + 1/2)
	function automatic longint round_div(longint num, longint d);
		longint x, y;
		x = 2 * num + d;
		y = 2 * d;
		if (x >= 0)
			return x / y;
		return -((-x + y - 1) / y);
	endfunction

	function automatic void predict_grid(logic [47:0] st, longint cur[6]);
		longint per, stamp, rel, k1, n, d, t;
		longint v[6];
		grid_word_t w;
		per = (period == 0) ? 1 : longint'(period);
		stamp = longint'({16'b0, st});
		if (!have_prev) begin
			base_off = stamp - longint'({32'b0, start_off});
			prev_t = longint'({32'b0, start_off});
			prev_vec = cur;
			have_prev = 1;
			return;
		end
		rel = stamp - base_off;
		if (rel < prev_t || rel > prev_t + longint'(jlim) * per)
			rel = prev_t + per;
		rel = rel & MASK48;
		base_off = stamp - rel;
		if (rel > prev_t) begin
			k1 = prev_t / per;
			n = rel / per - k1;
			d = rel - prev_t;
			if (n > imu_rs_pkg::MAX_OUTPUTS)
				n = imu_rs_pkg::MAX_OUTPUTS;
			for (longint k = 0; k < n; k++) begin
				t = (k1 + 1 + k) * per;
				for (int i = 0; i < 6; i++)
					v[i] = round_div(prev_vec[i] * (rel - t) + cur[i] * (t - prev_t), d) * per;
				w.t = t[47:0];
				w.th_a = v[1][47:0];
				w.th_b = v[0][47:0];
				w.th_c = 48'(-v[2]);
				w.dv_a = v[4][47:0];
				w.dv_b = v[3][47:0];
				w.dv_c = 48'(-v[5]);
				w.lst = (k == n - 1);
				grid_q = {grid_q, w};
			end
		end
		prev_t = rel;
		prev_vec = cur;
	endfunction

	task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint cur[6];
		grid_word_t w;
		if (!arst_n) begin
			period = imu_rs_pkg::PERIOD_RST;
			start_off = imu_rs_pkg::START_RST;
			jlim = imu_rs_pkg::JUMP_RST;
			have_prev = 0;
			base_off = 0;
			prev_t = 0;
			foreach (prev_vec[i]) prev_vec[i] = 0;
			grid_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (imu_rs_pkg::reg_idx_t'(cfg_addr))
					imu_rs_pkg::REG_PERIOD: period = cfg_wdata[15:0];
					imu_rs_pkg::REG_START:  start_off = cfg_wdata;
					imu_rs_pkg::REG_JUMP:   jlim = cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				cur[0] = rate_x;
				cur[1] = rate_y;
				cur[2] = rate_z;
				cur[3] = force_x;
				cur[4] = force_y;
				cur[5] = force_z;
				predict_grid(stamp_us, cur);
			end
			if (out_valid && out_ready) begin
				if (grid_q.size() == 0) begin
					// output word with nothing expected
					report_mismatch("out_valid", 48'd1, 48'd0);
				end else begin
					w = grid_q.pop_front();
					if (grid_time_us !== w.t) report_mismatch("grid_time_us", grid_time_us, w.t);
					if (dtheta_a !== w.th_a) report_mismatch("dtheta_a", dtheta_a, w.th_a);
					if (dtheta_b !== w.th_b) report_mismatch("dtheta_b", dtheta_b, w.th_b);
					if (dtheta_c !== w.th_c) report_mismatch("dtheta_c", dtheta_c, w.th_c);
					if (dvel_a !== w.dv_a) report_mismatch("dvel_a", dvel_a, w.dv_a);
					if (dvel_b !== w.dv_b) report_mismatch("dvel_b", dvel_b, w.dv_b);
					if (dvel_c !== w.dv_c) report_mismatch("dvel_c", dvel_c, w.dv_c);
					if (last !== w.lst) report_mismatch("last", 48'(last), 48'(w.lst));
				end
			end
		end
	end

endmodule

>>> tb/sv/imu_linear_resampler_tb.sv
// Stimulus and verdict for the IMU linear resampler testbench.
`timescale 1ns / 1ps

module imu_linear_resampler_tb;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 400;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [1:0]         cfg_addr = '0;
	logic [31:0]        cfg_wdata = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [47:0]        stamp_us = '0;
	logic signed [31:0] rate_x = '0, rate_y = '0, rate_z = '0;
	logic signed [31:0] force_x = '0, force_y = '0, force_z = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [47:0]        grid_time_us;
	logic signed [47:0] dtheta_a, dtheta_b, dtheta_c, dvel_a, dvel_b, dvel_c;
	logic               last;
	int                 errors, pending;
	int                 stall_cnt = 0;
	bit                 calm = 0;
	logic [47:0]        cur_stamp;

	always #10 clk = ~clk;

	imu_linear_resampler u_dut (.*);
	imu_linear_resampler_checker u_chk (.*);

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 27);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [31:0] pick_axis();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic cfg_write(imu_rs_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic [47:0] st);
		if (!calm && $urandom_range(99) < 27) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		stamp_us <= st;
		rate_x <= pick_axis();
		rate_y <= pick_axis();
		rate_z <= pick_axis();
		force_x <= pick_axis();
		force_y <= pick_axis();
		force_z <= pick_axis();
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid, let every word drain, then give the sequencer time to go idle
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] per, logic [5:0] jl, logic [31:0] start, int count);
		longint eff, span;
		int r;
		drain();
		cfg_write(imu_rs_pkg::REG_PERIOD, 32'(per));
		cfg_write(imu_rs_pkg::REG_JUMP, 32'(jl));
		cfg_write(imu_rs_pkg::REG_START, start);
		eff = (per == 0) ? 1 : per;
		span = eff * jl;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 80)
				cur_stamp += 48'($urandom_range(0, 32'(span)));
			else if (r < 88)
				cur_stamp -= 48'($urandom_range(1, 100000));
			else if (r < 94)
				cur_stamp += 48'(span + $urandom_range(1, 1000000));
			else
				cur_stamp = {16'($urandom), 32'($urandom)};
			send_sample(cur_stamp);
		end
	endtask

	initial begin
		longint dir_steps[15];
		dir_steps = '{5000, 0, 100000, 100001, -1, 2500, 2500, 7, 4993,
			-3000000, 20000, 1, 99999, 5000, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: first sample sets the base, then boundaries and jumps
		cfg_write(imu_rs_pkg::REG_START, 32'hFFFF_FFF0);
		cur_stamp = {16'($urandom), 32'($urandom)};
		send_sample(cur_stamp);
		foreach (dir_steps[i]) begin
			cur_stamp += 48'(dir_steps[i]);
			send_sample(cur_stamp);
		end
		send_sample(48'hFFFF_FFFF_FFFF);
		send_sample(48'h0);
		run_phase(16'd1, 6'd63, 32'd0, 15);
		run_phase(16'd65535, 6'd1, $urandom, 20);
		calm = 1;
		run_phase(16'd0, 6'd7, 32'hFFFF_FFFF, 15);
		calm = 0;
		run_phase(16'($urandom_range(1, 300)), 6'($urandom_range(1, 63)), $urandom, 30);
		run_phase(16'd5000, 6'd20, 32'd0, 15);
		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
